// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is ignored while reset is held.
`define KPFI_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked in the cycle after the trigger.
`define KPFI_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kpfi_pkg.sv =====
// Shared constants and types for the permutation block.
`timescale 1ns / 1ps

package kpfi_pkg;

  localparam int STATE_BITS = 257;
  localparam int SHUF_MULT  = 121;
  localparam int MIX_TAP_A  = 3;
  localparam int MIX_TAP_B  = 10;
  localparam int POS_W      = 9;
  localparam int RC_W       = 5;
  localparam logic [RC_W-1:0] RC_RESET = 5'd2;

  typedef struct packed {
    logic             fault_en;
    logic [POS_W-1:0] fault_pos;
    logic             flip_const;
  } kpfi_round_ctl_t;

  // Source bit of shuffle output bit i.
  function automatic int shuf_src(input int i);
    return (SHUF_MULT * i) % STATE_BITS;
  endfunction

endpackage

// ===== rtl/koala_permutation_fault_inject.sv =====
// Top level: word loader, round sequencer and result word unloader.
`timescale 1ns / 1ps

// Words are loaded one per start pulse while busy is low.
// The word with in_last set starts the permutation: busy stays high while
// the single round unit makes round_count passes, one per round (state
// held in one 257-bit register), and then while the NUM_WORDS result
// words are driven out. Each word shows on out_valid in the cycle after it is
// driven, so the final one, with out_last_res set, appears while busy is
// already low. Results cannot be stalled: sample them when out_valid is high.
// The user must write round_count through cfg_we/cfg_wdata only while idle;
// the block itself does not enforce this.
module koala_permutation_fault_inject #(
  parameter int WORD_WIDTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [WORD_WIDTH-1:0]       in_data_word,
  input  logic                        in_last,
  input  logic                        in_fault_enable,
  input  logic [kpfi_pkg::POS_W-1:0]  in_fault_position,
  output logic                        out_valid,
  output logic [WORD_WIDTH-1:0]       out_data_word_res,
  output logic                        out_last_res,
  input  logic                        cfg_we,
  input  logic [kpfi_pkg::RC_W-1:0]   cfg_wdata
);
  import kpfi_pkg::*;

  localparam int NUM_WORDS = (STATE_BITS + WORD_WIDTH - 1) / WORD_WIDTH;
  localparam int CNT_W     = $clog2(NUM_WORDS + 1);
  localparam int IDX_W     = $clog2(NUM_WORDS);
  localparam int PAD_W     = NUM_WORDS * WORD_WIDTH;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]            st_r, st_nxt;
  logic [RC_W-1:0]       round_cnt_r;
  logic [CNT_W-1:0]      load_cnt_r, load_cnt_nxt;
  logic [RC_W-1:0]       round_r, round_nxt;
  logic [IDX_W-1:0]      out_idx_r, out_idx_nxt;
  logic                  fault_en_r, fault_en_nxt;
  logic [POS_W-1:0]      fault_pos_r, fault_pos_nxt;
  logic [STATE_BITS-1:0] state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [WORD_WIDTH-1:0] out_data_r, out_data_nxt;

  logic [STATE_BITS-1:0] round_state;
  logic [PAD_W-1:0]      state_pad;
  kpfi_round_ctl_t       round_ctl;

  // Fault only in round 0; no constant flip in rounds one, four and five.
  always_comb begin
    round_ctl.fault_en   = fault_en_r && (round_r == '0);
    round_ctl.fault_pos  = fault_pos_r;
    round_ctl.flip_const = !((round_r == RC_W'(1)) || (round_r == RC_W'(4)) ||
                             (round_r == RC_W'(5)));
  end

  kpfi_round u_round (
    .state_in  (state_r),
    .ctl       (round_ctl),
    .state_out (round_state)
  );

  assign state_pad = PAD_W'(state_r);

  always_comb begin
    st_nxt        = st_r;
    load_cnt_nxt  = load_cnt_r;
    round_nxt     = round_r;
    out_idx_nxt   = out_idx_r;
    fault_en_nxt  = fault_en_r;
    fault_pos_nxt = fault_pos_r;
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_last_nxt  = 1'b0;
    out_data_nxt  = out_data_r;
    case (st_r)
      ST_LOAD: begin
        if (start) begin
          // Drop the beat once all words are in; bits past the state are lost.
          for (int i = 0; i < STATE_BITS; i++) begin
            if (load_cnt_r == CNT_W'(i / WORD_WIDTH)) begin
              state_nxt[i] = in_data_word[i % WORD_WIDTH];
            end
          end
          if (load_cnt_r < CNT_W'(NUM_WORDS)) begin
            load_cnt_nxt = load_cnt_r + CNT_W'(1);
          end
          if (in_last) begin
            load_cnt_nxt  = '0;
            fault_en_nxt  = in_fault_enable;
            fault_pos_nxt = in_fault_position;
            round_nxt     = '0;
            out_idx_nxt   = '0;
            st_nxt        = (round_cnt_r == '0) ? ST_OUT : ST_RUN;
          end
        end
      end
      ST_RUN: begin
        state_nxt = round_state;
        round_nxt = round_r + RC_W'(1);
        if (round_r == round_cnt_r - RC_W'(1)) begin
          st_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = state_pad[out_idx_r * WORD_WIDTH +: WORD_WIDTH];
        out_last_nxt  = (out_idx_r == IDX_W'(NUM_WORDS - 1));
        if (out_idx_r == IDX_W'(NUM_WORDS - 1)) begin
          st_nxt = ST_LOAD;
        end else begin
          out_idx_nxt = out_idx_r + IDX_W'(1);
        end
      end
      default: begin
        st_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_LOAD;
      round_cnt_r <= RC_RESET;
      load_cnt_r  <= '0;
      round_r     <= '0;
      out_idx_r   <= '0;
      fault_en_r  <= 1'b0;
      state_r     <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      load_cnt_r  <= load_cnt_nxt;
      round_r     <= round_nxt;
      out_idx_r   <= out_idx_nxt;
      fault_en_r  <= fault_en_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
      if (cfg_we) begin
        round_cnt_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    fault_pos_r <= fault_pos_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign busy              = (st_r != ST_LOAD);
  assign out_valid         = out_valid_r;
  assign out_data_word_res = out_data_r;
  assign out_last_res      = out_last_r;

endmodule

// ===== rtl/kpfi_round.sv =====
// One permutation round: shuffle, fault flip, mixing, constant flip, chi layer.
`timescale 1ns / 1ps

module kpfi_round (
  input  logic [kpfi_pkg::STATE_BITS-1:0] state_in,
  input  kpfi_pkg::kpfi_round_ctl_t        ctl,
  output logic [kpfi_pkg::STATE_BITS-1:0] state_out
);
  import kpfi_pkg::*;

  logic [STATE_BITS-1:0] shuf;
  logic [STATE_BITS-1:0] faulted;
  logic [STATE_BITS-1:0] mixed;

  always_comb begin
    for (int i = 0; i < STATE_BITS; i++) begin
      shuf[i] = state_in[shuf_src(i)];
    end
    for (int i = 0; i < STATE_BITS; i++) begin
      faulted[i] = shuf[i] ^ (ctl.fault_en && (ctl.fault_pos == POS_W'(i)));
    end
    for (int i = 0; i < STATE_BITS; i++) begin
      mixed[i] = faulted[i] ^ faulted[(i + MIX_TAP_A) % STATE_BITS]
               ^ faulted[(i + MIX_TAP_B) % STATE_BITS];
    end
    mixed[0] = mixed[0] ^ ctl.flip_const;
    for (int i = 0; i < STATE_BITS; i++) begin
      state_out[i] = mixed[i] ^ mixed[(i + 2) % STATE_BITS]
                   ^ (mixed[(i + 1) % STATE_BITS] & mixed[(i + 2) % STATE_BITS]);
    end
  end

endmodule

// ===== rtl/kpfi_checker.sv =====
// Port-level checks for the permutation block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kpfi_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_last,
  input logic out_valid,
  input logic out_last_res
);

  `KPFI_ASSERT(a_mid_word_busy, clk, rst_n, (out_valid && !out_last_res) |-> busy, "result beat while idle")
  `KPFI_ASSERT(a_last_has_valid, clk, rst_n, out_last_res |-> out_valid, "last flag without strobe")
  `KPFI_ASSERT_NEXT(a_frame_ends, clk, rst_n, out_valid && out_last_res, !out_valid, "beat after final word")
  `KPFI_ASSERT_NEXT(a_last_goes_busy, clk, rst_n, start && !busy && in_last, busy, "last beat did not start a run")
  `KPFI_ASSERT_NEXT(a_word_stays_idle, clk, rst_n, start && !busy && !in_last, !busy && !out_valid, "plain word caused work")

endmodule

bind koala_permutation_fault_inject kpfi_checker u_kpfi_checker (.*);
